// ===== rtl/core/srrip_lrf_pkg.sv =====
// shared types and constants for the srrip replacement block with lru reuse filter
package srrip_lrf_pkg;

    // field widths of the stream words
    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned SET_IDX_W = 11;
    localparam int unsigned WAY_W     = 4;
    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned VICTIM_W  = 4;
    localparam int unsigned S_DATA_W  = 88;
    localparam int unsigned M_DATA_W  = 8;

    // event kinds
    typedef enum logic [OPCODE_W-1:0] {
        OP_VICTIM = 2'd0,
        OP_HIT    = 2'd1,
        OP_FILL   = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    // status from the reuse filter back to the sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } filt_stat_t;

endpackage

// ===== rtl/core/srrip_lrf_ram.sv =====
// generic single write port ram with registered read
module srrip_lrf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/srrip_lrf_filter.sv =====
// fully associative lru reuse filter, scanned one entry per cycle
module srrip_lrf_filter #(
    parameter int unsigned FILTER_ENTRIES = 64,
    parameter int unsigned TAG_W          = 58
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [TAG_W-1:0]         line,
    output srrip_lrf_pkg::filt_stat_t stat
);
    import srrip_lrf_pkg::*;

    localparam int unsigned IDX_W = $clog2(FILTER_ENTRIES);
    localparam int unsigned CNT_W = $clog2(FILTER_ENTRIES + 1);
    localparam logic [IDX_W-1:0] REC_TOP = IDX_W'(FILTER_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(FILTER_ENTRIES);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SCAN = 3'b010,
        F_UPD  = 3'b100
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             valid_reg [FILTER_ENTRIES];
    logic             valid_next [FILTER_ENTRIES];
    logic [IDX_W-1:0] rec_reg [FILTER_ENTRIES];
    logic [IDX_W-1:0] rec_next [FILTER_ENTRIES];
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_slot_reg, hit_slot_next;
    logic [IDX_W-1:0] hit_old_reg, hit_old_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_slot_reg, free_slot_next;
    logic [IDX_W-1:0] min_slot_reg, min_slot_next;
    logic [IDX_W-1:0] min_val_reg, min_val_next;
    logic             done_reg, done_next;
    logic             hit_out_reg, hit_out_next;

    logic             tag_rd_en;
    logic [IDX_W-1:0] tag_rd_addr;
    logic [TAG_W-1:0] tag_rd_data;
    logic             tag_wr_en;
    logic [IDX_W-1:0] slot;
    logic             cmp_v;
    logic [IDX_W-1:0] cmp_r;

    // tag store
    srrip_lrf_ram #(
        .WIDTH (TAG_W),
        .DEPTH (FILTER_ENTRIES)
    ) u_tags (
        .aclk    (aclk),
        .wr_en   (tag_wr_en),
        .wr_addr (slot),
        .wr_data (line),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rd_data)
    );

    // read side of the scan
    assign tag_rd_en   = (state_reg == F_SCAN) && (cnt_reg != CNT_END);
    assign tag_rd_addr = cnt_reg[IDX_W-1:0];
    assign cmp_v       = valid_reg[cmp_idx_reg];
    assign cmp_r       = rec_reg[cmp_idx_reg];

    // replacement slot: the matching entry, else first free, else least recent
    assign slot = hit_found_reg  ? hit_slot_reg :
                  free_found_reg ? free_slot_reg : min_slot_reg;
    assign tag_wr_en = (state_reg == F_UPD) && !hit_found_reg;

    // scan and update sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        hit_found_next  = hit_found_reg;
        hit_slot_next   = hit_slot_reg;
        hit_old_next    = hit_old_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        min_slot_next   = min_slot_reg;
        min_val_next    = min_val_reg;
        done_next       = 1'b0;
        hit_out_next    = hit_out_reg;
        for (int j = 0; j < FILTER_ENTRIES; j++) begin
            valid_next[j] = valid_reg[j];
            rec_next[j]   = rec_reg[j];
        end
        case (state_reg)
            F_IDLE: begin
                if (start) begin
                    state_next      = F_SCAN;
                    cnt_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            F_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                // compare the entry read in the previous cycle
                if (cnt_reg != '0) begin
                    if (cmp_v && (tag_rd_data == line) && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_slot_next  = cmp_idx_reg;
                        hit_old_next   = cmp_r;
                    end
                    if (!cmp_v && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_slot_next  = cmp_idx_reg;
                    end
                    if ((cmp_idx_reg == '0) || (cmp_r < min_val_reg)) begin
                        min_slot_next = cmp_idx_reg;
                        min_val_next  = cmp_r;
                    end
                end
                if (cnt_reg == CNT_END) begin
                    state_next = F_UPD;
                end
            end
            F_UPD: begin
                // age the other entries and promote the chosen one
                for (int j = 0; j < FILTER_ENTRIES; j++) begin
                    if (hit_found_reg) begin
                        if (valid_reg[j] && (rec_reg[j] > hit_old_reg)) begin
                            rec_next[j] = rec_reg[j] - 1'b1;
                        end
                    end else if (valid_reg[j] && (IDX_W'(j) != slot) &&
                                 (rec_reg[j] != '0)) begin
                        rec_next[j] = rec_reg[j] - 1'b1;
                    end
                end
                rec_next[slot]   = REC_TOP;
                valid_next[slot] = 1'b1;
                done_next        = 1'b1;
                hit_out_next     = hit_found_reg;
                state_next       = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            for (int j = 0; j < FILTER_ENTRIES; j++) begin
                valid_reg[j] <= 1'b0;
                rec_reg[j]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            for (int j = 0; j < FILTER_ENTRIES; j++) begin
                valid_reg[j] <= valid_next[j];
                rec_reg[j]   <= rec_next[j];
            end
        end
    end

    // scan bookkeeping
    always_ff @(posedge aclk) begin
        cmp_idx_reg    <= cnt_reg[IDX_W-1:0];
        hit_found_reg  <= hit_found_next;
        hit_slot_reg   <= hit_slot_next;
        hit_old_reg    <= hit_old_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        min_slot_reg   <= min_slot_next;
        min_val_reg    <= min_val_next;
        hit_out_reg    <= hit_out_next;
    end

    assign stat.done = done_reg;
    assign stat.hit  = hit_out_reg;

endmodule

// ===== rtl/core/srrip_with_lru_reuse_filter.sv =====
// srrip replacement policy with an lru reuse filter guarding insertion
// path: victim and hit words go through read, max and row write after acceptance; fill
//   words first wait for the filter scan (one filter tag read per cycle), and a set
//   reduction step comes first when NUM_SETS is not a power of two and is below 2048
// throughput: one word at a time; the set row read-modify-write in one ram sets the pace
// reset: a clearing pass writes every set to maximum, s_tready low meanwhile; the filter
//   valid bits and recencies clear at once
module srrip_with_lru_reuse_filter #(
    parameter int unsigned NUM_SETS         = 2048,
    parameter int unsigned NUM_WAYS         = 16,
    parameter int unsigned REUSE_BITS       = 2,
    parameter int unsigned FILTER_ENTRIES   = 64,
    parameter int unsigned LINE_OFFSET_BITS = 6
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // opcode [1:0], set_index [12:2], way [16:13], address [80:17]
    input  logic [srrip_lrf_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // victim_way [3:0], filter_hit [4]
    output logic [srrip_lrf_pkg::M_DATA_W-1:0]   m_tdata
);
    import srrip_lrf_pkg::*;

    localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned ROW_W  = NUM_WAYS * REUSE_BITS;
    localparam int unsigned TAG_W  = ADDR_W - LINE_OFFSET_BITS;
    localparam int unsigned LEVELS = 1 << REUSE_BITS;
    localparam bit SET_DIRECT = (NUM_SETS >= (1 << SET_IDX_W)) ||
                                ((NUM_SETS & (NUM_SETS - 1)) == 0);
    localparam int unsigned MOD_TOP = SET_DIRECT ? 0 : (SET_IDX_W - $clog2(NUM_SETS));
    localparam logic [REUSE_BITS-1:0] RMAX = {REUSE_BITS{1'b1}};
    localparam logic [SET_W-1:0] CLR_END = SET_W'(NUM_SETS - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_FILT  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_MAX   = 7'b0100000,
        S_WRITE = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [SET_W-1:0]       clr_reg, clr_next;
    opcode_t                op_reg, op_next;
    logic [WAY_W-1:0]       way_reg, way_next;
    logic [SET_IDX_W-1:0]   rem_reg, rem_next;
    logic [3:0]             k_reg, k_next;
    logic [TAG_W-1:0]       line_reg, line_next;
    logic                   fhit_reg, fhit_next;
    logic [REUSE_BITS-1:0]  top_reg, top_next;
    logic [ROW_W-1:0]       vals_reg, vals_next;
    logic                   filt_start_reg, filt_start_next;
    logic                   m_valid_reg, m_valid_next;
    logic [VICTIM_W-1:0]    victim_out_reg, victim_out_next;
    logic                   fhit_out_reg, fhit_out_next;

    logic                   accept;
    opcode_t                in_op;
    logic [27:0]            mod_sub;
    logic [SET_W-1:0]       set_addr;
    logic                   out_free;
    logic                   way_ok;
    logic [REUSE_BITS-1:0]  lift;
    logic [ROW_W-1:0]       row_new;
    logic [VICTIM_W-1:0]    vict;
    logic                   vict_found;
    logic [LEVELS-1:0]      lvl_hit;
    logic                   ram_wr_en;
    logic [SET_W-1:0]       ram_wr_addr;
    logic [ROW_W-1:0]       ram_wr_data;
    logic                   ram_rd_en;
    logic [ROW_W-1:0]       ram_rd_data;
    filt_stat_t             filt_stat;

    // next step once the set is known
    function automatic state_t route(input opcode_t op);
        state_t st;
        case (op)
            OP_FILL: st = S_FILT;
            OP_NOP:  st = S_WRITE;
            default: st = S_READ;
        endcase
        return st;
    endfunction

    // reuse value store, one row of ways per set
    srrip_lrf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_reuse (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (set_addr),
        .rd_data (ram_rd_data)
    );

    // reuse filter
    srrip_lrf_filter #(
        .FILTER_ENTRIES (FILTER_ENTRIES),
        .TAG_W          (TAG_W)
    ) u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (filt_start_reg),
        .line    (line_reg),
        .stat    (filt_stat)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_op    = opcode_t'(s_tdata[1:0]);
    assign out_free = !m_valid_reg || m_tready;

    // set reduction by shifted compare and subtract
    assign mod_sub  = 28'(NUM_SETS) << k_reg;
    assign set_addr = (NUM_SETS == 1) ? '0 : SET_W'(rem_reg);
    assign way_ok   = 6'(way_reg) < 6'(NUM_WAYS);
    assign lift     = RMAX - top_reg;

    // which reuse levels are present in the row just read
    always_comb begin
        for (int v = 0; v < LEVELS; v++) begin
            lvl_hit[v] = 1'b0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (ram_rd_data[w*REUSE_BITS +: REUSE_BITS] == REUSE_BITS'(v)) begin
                    lvl_hit[v] = 1'b1;
                end
            end
        end
        top_next = '0;
        for (int v = 0; v < LEVELS; v++) begin
            if (lvl_hit[v]) begin
                top_next = REUSE_BITS'(v);
            end
        end
    end

    // new row and victim from the held row
    always_comb begin
        row_new    = vals_reg;
        vict       = '0;
        vict_found = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!vict_found && (vals_reg[w*REUSE_BITS +: REUSE_BITS] == top_reg)) begin
                vict       = VICTIM_W'(w);
                vict_found = 1'b1;
            end
            case (op_reg)
                OP_VICTIM: begin
                    row_new[w*REUSE_BITS +: REUSE_BITS] =
                        vals_reg[w*REUSE_BITS +: REUSE_BITS] + lift;
                end
                OP_HIT: begin
                    if (6'(w) == 6'(way_reg)) begin
                        row_new[w*REUSE_BITS +: REUSE_BITS] = '0;
                    end
                end
                OP_FILL: begin
                    if (6'(w) == 6'(way_reg)) begin
                        row_new[w*REUSE_BITS +: REUSE_BITS] = fhit_reg ? '0 : RMAX;
                    end
                end
                default: begin
                    row_new = vals_reg;
                end
            endcase
        end
    end

    // ram write port shared by the clearing pass and the row update
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = set_addr;
        ram_wr_data = row_new;
        if (state_reg == S_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_reg;
            ram_wr_data = {ROW_W{1'b1}};
        end else if ((state_reg == S_WRITE) && out_free) begin
            ram_wr_en = (op_reg == OP_VICTIM) ||
                        (((op_reg == OP_HIT) || (op_reg == OP_FILL)) && way_ok);
        end
    end
    assign ram_rd_en = (state_reg == S_READ);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        way_next        = way_reg;
        rem_next        = rem_reg;
        k_next          = k_reg;
        line_next       = line_reg;
        fhit_next       = fhit_reg;
        vals_next       = vals_reg;
        victim_out_next = victim_out_reg;
        fhit_out_next   = fhit_out_reg;
        m_valid_next    = m_tready ? 1'b0 : m_valid_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_END) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    op_next    = in_op;
                    rem_next   = s_tdata[12:2];
                    way_next   = s_tdata[16:13];
                    line_next  = s_tdata[80:17+LINE_OFFSET_BITS];
                    k_next     = 4'(MOD_TOP);
                    fhit_next  = 1'b0;
                    state_next = SET_DIRECT ? route(in_op) : S_MOD;
                end
            end
            S_MOD: begin
                if (28'(rem_reg) >= mod_sub) begin
                    rem_next = rem_reg - mod_sub[SET_IDX_W-1:0];
                end
                if (k_reg == '0) begin
                    state_next = route(op_reg);
                end else begin
                    k_next = k_reg - 1'b1;
                end
            end
            S_FILT: begin
                if (filt_stat.done) begin
                    fhit_next  = filt_stat.hit;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_MAX;
            end
            S_MAX: begin
                vals_next  = ram_rd_data;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    victim_out_next = (op_reg == OP_VICTIM) ? vict : '0;
                    fhit_out_next   = (op_reg == OP_FILL) ? fhit_reg : 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign filt_start_next = (state_next == S_FILT) && (state_reg != S_FILT);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            filt_start_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            filt_start_reg <= filt_start_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        way_reg        <= way_next;
        rem_reg        <= rem_next;
        k_reg          <= k_next;
        line_reg       <= line_next;
        fhit_reg       <= fhit_next;
        top_reg        <= top_next;
        vals_reg       <= vals_next;
        victim_out_reg <= victim_out_next;
        fhit_out_reg   <= fhit_out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, fhit_out_reg, victim_out_reg};

    // filter only reports back while the sequencer waits for it
    a_filt_done_in_filt: assert property (@(posedge aclk) disable iff (!aresetn)
        filt_stat.done |-> (state_reg == S_FILT))
        else $error("filter done outside of filter wait");

    // a new result only comes out of the row update step
    a_result_from_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_WRITE))
        else $error("result raised outside of row update");

    // filter hit is only reported for fills
    a_fhit_only_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_WRITE) && out_free && (op_reg != OP_FILL)) |=> !fhit_out_reg)
        else $error("filter hit reported for a non-fill word");

endmodule

// ===== tb/srrip_lrf_checker.sv =====
// result checker for the srrip block: predicts every result word and compares it
module srrip_lrf_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [srrip_lrf_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [srrip_lrf_pkg::M_DATA_W-1:0] m_tdata,
    output int unsigned                        errors,
    output int unsigned                        pending,
    output int unsigned                        checked,
    output int unsigned                        reuse_hits,
    output int unsigned                        evictions,
    output int unsigned                        agings
);
    import srrip_lrf_pkg::*;

    localparam int unsigned NSETS    = 2048;
    localparam int unsigned NWAYS    = 16;
    localparam int unsigned RBITS    = 2;
    localparam int unsigned RMAX     = (1 << RBITS) - 1;
    localparam int unsigned NFILT    = 64;
    localparam int unsigned OFFS     = 6;
    localparam int unsigned TAG_W    = ADDR_W - OFFS;
    localparam int unsigned AGE_W    = 6;
    localparam int unsigned SET_LSB  = OPCODE_W;
    localparam int unsigned WAY_LSB  = SET_LSB + SET_IDX_W;
    localparam int unsigned ADDR_LSB = WAY_LSB + WAY_W;

    typedef struct packed {
        logic [VICTIM_W-1:0] victim_way;
        logic                filter_hit;
    } outcome_t;

    // model copy of the re-reference store and the reuse filter
    logic [RBITS-1:0] rrpv [NSETS][NWAYS];
    logic             flt_valid [NFILT];
    logic [AGE_W-1:0] flt_age [NFILT];
    logic [TAG_W-1:0] flt_tag [NFILT];

    outcome_t    predicted_outcomes [$];
    outcome_t    want;
    int unsigned err_cnt, chk_cnt, reuse_cnt, evict_cnt, aging_cnt;

    // first way at maximum, aging the whole set first when none is there
    function automatic logic [VICTIM_W-1:0] choose_victim(input int unsigned s);
        logic [RBITS-1:0]    top;
        logic [VICTIM_W-1:0] pick;
        top  = '0;
        pick = '0;
        for (int w = 0; w < NWAYS; w++)
            if (rrpv[s][w] > top) top = rrpv[s][w];
        if (top < RMAX) begin
            aging_cnt++;
            for (int w = 0; w < NWAYS; w++)
                rrpv[s][w] = rrpv[s][w] + RBITS'(RMAX - top);
        end
        for (int w = NWAYS - 1; w >= 0; w--)
            if (rrpv[s][w] == RBITS'(RMAX)) pick = VICTIM_W'(w);
        return pick;
    endfunction

    // lru filter lookup; installs the line on a miss, returns 1 on a hit
    function automatic bit filter_lookup(input logic [TAG_W-1:0] tag);
        int               slot;
        logic [AGE_W-1:0] old_age;
        slot = -1;
        for (int i = 0; i < NFILT; i++)
            if (slot < 0 && flt_valid[i] && flt_tag[i] == tag) slot = i;
        if (slot >= 0) begin
            old_age = flt_age[slot];
            for (int i = 0; i < NFILT; i++)
                if (flt_valid[i] && flt_age[i] > old_age) flt_age[i]--;
            flt_age[slot] = AGE_W'(NFILT - 1);
            return 1'b1;
        end
        for (int i = 0; i < NFILT; i++)
            if (slot < 0 && !flt_valid[i]) slot = i;
        // full filter: lowest-numbered entry of least recency goes
        if (slot < 0) begin
            slot = 0;
            evict_cnt++;
            for (int i = 1; i < NFILT; i++)
                if (flt_age[i] < flt_age[slot]) slot = i;
        end
        flt_valid[slot] = 1'b1;
        flt_tag[slot]   = tag;
        for (int i = 0; i < NFILT; i++)
            if (flt_valid[i] && i != slot && flt_age[i] != 0) flt_age[i]--;
        flt_age[slot] = AGE_W'(NFILT - 1);
        return 1'b0;
    endfunction

    // apply one event word to the model and give its result
    function automatic outcome_t policy_step(input logic [S_DATA_W-1:0] word);
        opcode_t           op;
        int unsigned       s;
        int unsigned       w;
        logic [ADDR_W-1:0] addr;
        outcome_t          o;
        bit                reuse;
        op   = opcode_t'(word[OPCODE_W-1:0]);
        s    = word[SET_LSB +: SET_IDX_W] % NSETS;
        w    = word[WAY_LSB +: WAY_W];
        addr = word[ADDR_LSB +: ADDR_W];
        o    = '0;
        case (op)
            OP_VICTIM: o.victim_way = choose_victim(s);
            OP_HIT: begin
                if (w < NWAYS) rrpv[s][w] = '0;
            end
            OP_FILL: begin
                reuse        = filter_lookup(addr[ADDR_W-1:OFFS]);
                o.filter_hit = reuse;
                if (reuse) reuse_cnt++;
                if (w < NWAYS) rrpv[s][w] = reuse ? '0 : RBITS'(RMAX);
            end
            default: ;
        endcase
        return o;
    endfunction

    // watch both channels, compare before predicting the word taken this edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NSETS; s++)
                for (int w = 0; w < NWAYS; w++) rrpv[s][w] = RBITS'(RMAX);
            for (int i = 0; i < NFILT; i++) begin
                flt_valid[i] = 1'b0;
                flt_age[i]   = '0;
                flt_tag[i]   = '0;
            end
            predicted_outcomes.delete();
            err_cnt   = 0;
            chk_cnt   = 0;
            reuse_cnt = 0;
            evict_cnt = 0;
            aging_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_outcomes.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result word with none expected: expected nothing, got %h",
                             $time, m_tdata);
                end else begin
                    want = predicted_outcomes.pop_front();
                    chk_cnt++;
                    if (m_tdata[0 +: VICTIM_W] !== want.victim_way) begin
                        err_cnt++;
                        $display("%0t: victim_way expected %0d, got %0d",
                                 $time, want.victim_way, m_tdata[0 +: VICTIM_W]);
                    end
                    if (m_tdata[VICTIM_W] !== want.filter_hit) begin
                        err_cnt++;
                        $display("%0t: filter_hit expected %0d, got %0d",
                                 $time, want.filter_hit, m_tdata[VICTIM_W]);
                    end
                end
            end
            if (s_tvalid && s_tready) predicted_outcomes.push_back(policy_step(s_tdata));
        end
        errors     <= err_cnt;
        pending    <= predicted_outcomes.size();
        checked    <= chk_cnt;
        reuse_hits <= reuse_cnt;
        evictions  <= evict_cnt;
        agings     <= aging_cnt;
    end

endmodule

// ===== tb/testbench.sv =====
// top of the srrip block test: clock, reset, event stimulus, result stalls and verdict
module testbench;
    import srrip_lrf_pkg::*;

    localparam int unsigned OFFS      = 6;
    localparam int unsigned POOL_LEN  = 80;
    localparam int unsigned HOT_SETS  = 5;
    localparam int unsigned RAND_WORDS = 450;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tready = 1'b0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire  [M_DATA_W-1:0] m_tdata;

    logic        calm       = 1'b0;
    int unsigned stall_left = 0;
    int unsigned sent       = 0;
    int unsigned errors, pending, checked, reuse_hits, evictions, agings;

    logic [ADDR_W-OFFS-1:0] line_pool [POOL_LEN];
    logic [SET_IDX_W-1:0]   hot_set [HOT_SETS];

    srrip_with_lru_reuse_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    srrip_lrf_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .reuse_hits (reuse_hits),
        .evictions  (evictions),
        .agings     (agings)
    );

    always #5 aclk = ~aclk;

    // result side stalls at random times, in bursts of random length
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // offer one event word, maybe after an idle burst, and wait until taken
    task automatic send_word(input opcode_t op, input logic [SET_IDX_W-1:0] set_idx,
                             input logic [WAY_W-1:0] way, input logic [ADDR_W-1:0] addr);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - ADDR_W - WAY_W - SET_IDX_W - OPCODE_W){1'b0}},
                     addr, way, set_idx, op};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    initial begin
        int unsigned          r;
        opcode_t              op;
        logic [SET_IDX_W-1:0] set_idx;
        logic [ADDR_W-1:0]    addr;

        foreach (line_pool[i]) line_pool[i] = (ADDR_W - OFFS)'({$urandom, $urandom});
        foreach (hot_set[i]) hot_set[i] = SET_IDX_W'($urandom);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // fresh set, then a hit moves the victim along
        send_word(OP_VICTIM, '0, '0, '0);
        send_word(OP_HIT, '0, '0, '0);
        send_word(OP_VICTIM, '0, '0, '0);
        // every way of the top set hit, so the victim search must age the set
        for (int w = 0; w < 16; w++) send_word(OP_HIT, '1, WAY_W'(w), '0);
        send_word(OP_VICTIM, '1, '0, '1);
        // filter miss, then the same line at another byte offset hits
        send_word(OP_FILL, '0, 4'd1, 64'h0);
        send_word(OP_FILL, '0, 4'd2, 64'h3F);
        send_word(OP_VICTIM, '0, '0, '0);
        send_word(OP_FILL, '1, '1, '1);
        // nop opcode changes nothing but still gives a result word
        send_word(OP_NOP, '1, '1, '1);

        // random events, mostly on a few hot sets and a reused line pool
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == RAND_WORDS - 60) calm <= 1'b1;
            r  = $urandom_range(0, 99);
            op = r < 30 ? OP_VICTIM : r < 58 ? OP_HIT : r < 93 ? OP_FILL : OP_NOP;
            set_idx = ($urandom_range(0, 4) == 0) ? SET_IDX_W'($urandom)
                                                  : hot_set[$urandom_range(0, HOT_SETS - 1)];
            if ($urandom_range(0, 9) < 7)
                addr = {line_pool[$urandom_range(0, POOL_LEN - 1)], OFFS'($urandom)};
            else
                addr = {$urandom, $urandom};
            send_word(op, set_idx, WAY_W'($urandom), addr);
        end
        s_tvalid <= 1'b0;

        // drain outstanding results, then allow for a fill still in flight
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);

        $display("sent %0d event words, checked %0d results, %0d fills hit the filter",
                 sent, checked, reuse_hits);
        $display("filter replacements: %0d, victim searches that aged a set: %0d",
                 evictions, agings);
        if (errors == 0 && pending == 0) begin
            $display("** srrip_with_lru_reuse_filter: PASSED **");
        end else begin
            $display("** srrip_with_lru_reuse_filter: FAILED **");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #5_000_000;
        $display("** srrip_with_lru_reuse_filter: FAILED **");
        $finish;
    end

endmodule
